// ===== rtl/core/psd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants of the point to segment distance block.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int DIST_W = 17;
    localparam logic [DIST_W-1:0] DIST_MAX = 17'h1FFFF;

    typedef enum logic [1:0] {
        REGION_START    = 2'd0,
        REGION_END      = 2'd1,
        REGION_INTERIOR = 2'd2
    } t_region;

endpackage

// ===== rtl/core/point_segment_distance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance
// Distance from a 3-D query point to a line segment, fixed point, pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the segment endpoints and the query point and raise start for one
//   cycle; a beat is taken on every edge with start high and busy low. busy
//   stays low, so a new beat may be offered on every cycle.
//   Each beat yields one result: o_valid pulses for one cycle together with
//   o_seg_distance (unsigned, same fraction bits as the inputs, truncated)
//   and o_region (nearest first endpoint, nearest second endpoint, or
//   interior projection). Results leave in the order the beats came in;
//   throughput is one beat per cycle. The depth is set by the operand
//   stages, the divider (one quotient bit per stage), the square root (one
//   root bit per stage) and the output register. Endpoint cases pass through
//   the divider with a divisor of one. Reset clears all valid bits; beats
//   in flight are dropped. The receiver cannot stall the block, the result
//   is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module point_segment_distance import psd_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_start_z,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_z,
    input  logic signed [COORD_WIDTH-1:0] i_query_x,
    input  logic signed [COORD_WIDTH-1:0] i_query_y,
    input  logic signed [COORD_WIDTH-1:0] i_query_z,
    output logic                          o_valid,
    output logic [DIST_W-1:0]             o_seg_distance,
    output logic [1:0]                    o_region
);

    localparam int W   = COORD_WIDTH;
    localparam int DFW = W + 1;         // coordinate difference
    localparam int PW  = 2 * W + 2;     // product of two differences
    localparam int SW  = 2 * W + 4;     // sum of three products
    localparam int CW  = 2 * W + 3;     // cross product component
    localparam int CMW = 2 * W + 2;     // its magnitude
    localparam int CSQ = 4 * W + 4;     // its square
    localparam int NW  = 4 * W + 6;     // dividend
    localparam int QW  = 2 * W + 4;     // quotient, also sqrt radicand
    localparam int RW  = QW / 2;
    localparam int MW  = (RW > DIST_W) ? RW : DIST_W;

    assign busy = 1'b0;

    // stage 1: difference vectors u = e - s, v = q - s, w = q - e
    logic signed [DFW-1:0] r_u [0:2];
    logic signed [DFW-1:0] r_v [0:2];
    logic signed [DFW-1:0] r_w [0:2];
    logic                  r_vld1;

    always_ff @(posedge i_clk) begin
        r_u[0] <= DFW'(i_end_x) - DFW'(i_start_x);
        r_u[1] <= DFW'(i_end_y) - DFW'(i_start_y);
        r_u[2] <= DFW'(i_end_z) - DFW'(i_start_z);
        r_v[0] <= DFW'(i_query_x) - DFW'(i_start_x);
        r_v[1] <= DFW'(i_query_y) - DFW'(i_start_y);
        r_v[2] <= DFW'(i_query_z) - DFW'(i_start_z);
        r_w[0] <= DFW'(i_query_x) - DFW'(i_end_x);
        r_w[1] <= DFW'(i_query_y) - DFW'(i_end_y);
        r_w[2] <= DFW'(i_query_z) - DFW'(i_end_z);
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= start && !busy;
        end
    end

    // stage 2: all component products
    logic signed [PW-1:0] r_puu [0:2];
    logic signed [PW-1:0] r_pvu [0:2];
    logic signed [PW-1:0] r_pwu [0:2];
    logic signed [PW-1:0] r_pvv [0:2];
    logic signed [PW-1:0] r_pww [0:2];
    logic signed [PW-1:0] r_pxa [0:2];   // first term of each cross component
    logic signed [PW-1:0] r_pxb [0:2];   // second term
    logic                 r_vld2;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_puu[i] <= PW'(r_u[i]) * PW'(r_u[i]);
            r_pvu[i] <= PW'(r_v[i]) * PW'(r_u[i]);
            r_pwu[i] <= PW'(r_w[i]) * PW'(r_u[i]);
            r_pvv[i] <= PW'(r_v[i]) * PW'(r_v[i]);
            r_pww[i] <= PW'(r_w[i]) * PW'(r_w[i]);
        end
        r_pxa[0] <= PW'(r_v[1]) * PW'(r_u[2]);
        r_pxb[0] <= PW'(r_v[2]) * PW'(r_u[1]);
        r_pxa[1] <= PW'(r_v[2]) * PW'(r_u[0]);
        r_pxb[1] <= PW'(r_v[0]) * PW'(r_u[2]);
        r_pxa[2] <= PW'(r_v[0]) * PW'(r_u[1]);
        r_pxb[2] <= PW'(r_v[1]) * PW'(r_u[0]);
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else begin
            r_vld2 <= r_vld1;
        end
    end

    // stage 3: dot products, squared lengths, cross product
    logic signed [SW-1:0] r_uu, r_vu, r_wu, r_vv, r_ww;
    logic signed [CW-1:0] r_c [0:2];
    logic                 r_vld3;

    always_ff @(posedge i_clk) begin
        r_uu <= SW'(r_puu[0]) + SW'(r_puu[1]) + SW'(r_puu[2]);
        r_vu <= SW'(r_pvu[0]) + SW'(r_pvu[1]) + SW'(r_pvu[2]);
        r_wu <= SW'(r_pwu[0]) + SW'(r_pwu[1]) + SW'(r_pwu[2]);
        r_vv <= SW'(r_pvv[0]) + SW'(r_pvv[1]) + SW'(r_pvv[2]);
        r_ww <= SW'(r_pww[0]) + SW'(r_pww[1]) + SW'(r_pww[2]);
        for (int i = 0; i < 3; i++) begin
            r_c[i] <= CW'(r_pxa[i]) - CW'(r_pxb[i]);
        end
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else begin
            r_vld3 <= r_vld2;
        end
    end

    // stage 4: region decision, squares of the cross components
    t_region          n_region;
    logic [CW-1:0]    w_cabs [0:2];
    logic [CMW-1:0]   w_cmag [0:2];
    t_region          r_region4;
    logic [SW-1:0]    r_uu4, r_vv4, r_ww4;
    logic [CSQ-1:0]   r_csq [0:2];
    logic             r_vld4;

    always_comb begin
        if (r_uu == '0 || r_vu < 0) begin
            n_region = REGION_START;
        end else if (r_wu > 0) begin
            n_region = REGION_END;
        end else begin
            n_region = REGION_INTERIOR;
        end
        for (int i = 0; i < 3; i++) begin
            w_cabs[i] = r_c[i][CW-1] ? CW'(-r_c[i]) : CW'(r_c[i]);
            w_cmag[i] = w_cabs[i][CMW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_region4 <= n_region;
        r_uu4     <= r_uu;
        r_vv4     <= r_vv;
        r_ww4     <= r_ww;
        for (int i = 0; i < 3; i++) begin
            r_csq[i] <= CSQ'(w_cmag[i]) * CSQ'(w_cmag[i]);
        end
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
        end else begin
            r_vld4 <= r_vld3;
        end
    end

    // stage 5: divider operands; endpoint cases divide by one
    logic [NW-1:0] r_num;
    logic [SW-1:0] r_den;
    t_region       r_region5;
    logic          r_vld5;

    always_ff @(posedge i_clk) begin
        r_region5 <= r_region4;
        case (r_region4)
            REGION_START: begin
                r_num <= NW'(r_vv4);
                r_den <= SW'(1);
            end
            REGION_END: begin
                r_num <= NW'(r_ww4);
                r_den <= SW'(1);
            end
            default: begin
                r_num <= NW'(r_csq[0]) + NW'(r_csq[1]) + NW'(r_csq[2]);
                r_den <= r_uu4;
            end
        endcase
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
        end else begin
            r_vld5 <= r_vld4;
        end
    end

    logic          w_div_vld;
    logic [QW-1:0] w_quo;
    t_region       w_div_tag;

    psd_div #(
        .NW (NW),
        .DW (SW),
        .QW (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld5),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_tag   (r_region5),
        .o_valid (w_div_vld),
        .o_quo   (w_quo),
        .o_tag   (w_div_tag)
    );

    logic          w_sq_vld;
    logic [RW-1:0] w_root;
    t_region       w_sq_tag;

    psd_sqrt #(
        .IW (QW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_vld),
        .i_rad   (w_quo),
        .i_tag   (w_div_tag),
        .o_valid (w_sq_vld),
        .o_root  (w_root),
        .o_tag   (w_sq_tag)
    );

    // output register with saturation
    logic r_out_vld;

    always_ff @(posedge i_clk) begin
        if (MW'(w_root) > MW'(DIST_MAX)) begin
            o_seg_distance <= DIST_MAX;
        end else begin
            o_seg_distance <= DIST_W'(w_root);
        end
        o_region <= w_sq_tag;
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_sq_vld;
        end
    end

    assign o_valid = r_out_vld;

endmodule

// ===== rtl/core/psd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_div
// Pipelined restoring divider, one quotient bit per stage, tag carried along.
// ----------------------------------------------------------------------------
module psd_div import psd_pkg::*; #(
    parameter int NW = 70,
    parameter int DW = 36,
    parameter int QW = 36
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  t_region       i_tag,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output t_region       o_tag
);

    logic [DW-1:0] r_rem [0:QW-1];
    logic [QW-1:0] r_lo  [0:QW-1];
    logic [QW-1:0] r_quo [0:QW-1];
    logic [DW-1:0] r_den [0:QW-1];
    t_region       r_tag [0:QW-1];
    logic [QW-1:0] r_vld;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] a_rem;
        logic [QW-1:0] a_lo;
        logic [QW-1:0] a_quo;
        logic [DW-1:0] a_den;
        t_region       a_tag;
        logic          a_vld;
        logic [DW:0]   w_shift;
        logic [DW:0]   w_diff;
        logic          w_ge;

        if (k == 0) begin : g_in
            // the quotient fits QW bits, so the upper numerator part is below den
            assign a_rem = DW'(i_num[NW-1:QW]);
            assign a_lo  = i_num[QW-1:0];
            assign a_quo = '0;
            assign a_den = i_den;
            assign a_tag = i_tag;
            assign a_vld = i_valid;
        end else begin : g_chain
            assign a_rem = r_rem[k-1];
            assign a_lo  = r_lo[k-1];
            assign a_quo = r_quo[k-1];
            assign a_den = r_den[k-1];
            assign a_tag = r_tag[k-1];
            assign a_vld = r_vld[k-1];
        end

        always_comb begin
            w_shift = {a_rem, a_lo[QW-1]};
            w_diff  = w_shift - {1'b0, a_den};
            w_ge    = (w_shift >= {1'b0, a_den});
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= w_ge ? w_diff[DW-1:0] : w_shift[DW-1:0];
            r_lo[k]  <= {a_lo[QW-2:0], 1'b0};
            r_quo[k] <= {a_quo[QW-2:0], w_ge};
            r_den[k] <= a_den;
            r_tag[k] <= a_tag;
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= a_vld;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_tag   = r_tag[QW-1];

endmodule

// ===== rtl/core/psd_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psd_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module psd_sqrt import psd_pkg::*; #(
    parameter int IW = 36
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [IW-1:0]   i_rad,
    input  t_region         i_tag,
    output logic            o_valid,
    output logic [IW/2-1:0] o_root,
    output t_region         o_tag
);

    localparam int RW = IW / 2;

    logic [RW+1:0] r_rem  [0:RW-1];
    logic [RW-1:0] r_root [0:RW-1];
    logic [IW-1:0] r_rad  [0:RW-1];
    t_region       r_tag  [0:RW-1];
    logic [RW-1:0] r_vld;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW+1:0] a_rem;
        logic [RW-1:0] a_root;
        logic [IW-1:0] a_rad;
        t_region       a_tag;
        logic          a_vld;
        logic [RW+3:0] w_shift;
        logic [RW+3:0] w_trial;
        logic [RW+3:0] w_diff;
        logic          w_ge;

        if (k == 0) begin : g_in
            assign a_rem  = '0;
            assign a_root = '0;
            assign a_rad  = i_rad;
            assign a_tag  = i_tag;
            assign a_vld  = i_valid;
        end else begin : g_chain
            assign a_rem  = r_rem[k-1];
            assign a_root = r_root[k-1];
            assign a_rad  = r_rad[k-1];
            assign a_tag  = r_tag[k-1];
            assign a_vld  = r_vld[k-1];
        end

        always_comb begin
            w_shift = {a_rem, a_rad[IW-1:IW-2]};
            w_trial = {2'b00, a_root, 2'b01};
            w_diff  = w_shift - w_trial;
            w_ge    = (w_shift >= w_trial);
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= w_ge ? w_diff[RW+1:0] : w_shift[RW+1:0];
            r_root[k] <= {a_root[RW-2:0], w_ge};
            r_rad[k]  <= {a_rad[IW-3:0], 2'b00};
            r_tag[k]  <= a_tag;
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= a_vld;
            end
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_tag   = r_tag[RW-1];

endmodule

// ===== tb/point_segment_distance_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_segment_distance_tb
// Self-checking bench for the 3-D point to segment distance block.
// ----------------------------------------------------------------------------
// A queue of segment/point queries feeds a falling-edge driver with random
// gaps. Each accepted beat is run through an exact integer model of the
// distance and region, and every o_valid beat is compared in order with it.
// ----------------------------------------------------------------------------
module point_segment_distance_tb import psd_pkg::*; ();

    localparam int CW        = 16;
    localparam int LATENCY   = 60;
    localparam int CYCLE_CAP = 300000;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct {
        t_coord sx, sy, sz, ex, ey, ez, qx, qy, qz;
    } t_seg_query;

    typedef struct {
        logic [DIST_W-1:0] distance;
        t_region           region;
    } t_dist_result;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_coord i_start_x, i_start_y, i_start_z;
    t_coord i_end_x, i_end_y, i_end_z;
    t_coord i_query_x, i_query_y, i_query_z;
    logic o_valid;
    logic [DIST_W-1:0] o_seg_distance;
    logic [1:0] o_region;

    t_seg_query   query_queue[$];
    t_dist_result expected_dist[$];
    logic         beat_taken;
    int           gap_left;
    int           burst_left;
    int           error_count;
    int           cycle_count;

    point_segment_distance #(.COORD_WIDTH(CW)) dut (.*);

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // floor of the square root
    function automatic logic [63:0] isqrt(input logic [127:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 39; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= n) r = c;
        end
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] clamp_dist(input logic [63:0] d);
        return (d > DIST_MAX) ? DIST_MAX : d[DIST_W-1:0];
    endfunction

    function automatic t_dist_result predict_distance(input t_seg_query q);
        longint u[3], v[3], w[3], c[3];
        longint uu, vu, wu;
        logic [127:0] num, m;
        t_dist_result r;
        u = '{q.ex - q.sx, q.ey - q.sy, q.ez - q.sz};
        v = '{q.qx - q.sx, q.qy - q.sy, q.qz - q.sz};
        w = '{q.qx - q.ex, q.qy - q.ey, q.qz - q.ez};
        uu = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
        vu = v[0]*u[0] + v[1]*u[1] + v[2]*u[2];
        wu = w[0]*u[0] + w[1]*u[1] + w[2]*u[2];
        if (uu == 0 || vu < 0) begin
            r.distance = clamp_dist(isqrt(v[0]*v[0] + v[1]*v[1] + v[2]*v[2]));
            r.region   = REGION_START;
        end else if (wu > 0) begin
            r.distance = clamp_dist(isqrt(w[0]*w[0] + w[1]*w[1] + w[2]*w[2]));
            r.region   = REGION_END;
        end else begin
            c[0] = v[1]*u[2] - v[2]*u[1];
            c[1] = v[2]*u[0] - v[0]*u[2];
            c[2] = v[0]*u[1] - v[1]*u[0];
            num = '0;
            for (int i = 0; i < 3; i++) begin
                m = (c[i] < 0) ? 128'(-c[i]) : 128'(c[i]);
                num += m * m;
            end
            r.distance = clamp_dist(isqrt(num / 128'(uu)));
            r.region   = REGION_INTERIOR;
        end
        return r;
    endfunction

    function automatic t_coord rand_coord(input int span);
        if (span == 0) return t_coord'($urandom);
        return t_coord'(int'($urandom_range(0, 2*span)) - span);
    endfunction

    function automatic t_seg_query rand_query();
        t_seg_query q;
        int pick, t;
        int span;
        pick = $urandom_range(0, 9);
        span = (pick < 3) ? 0 : ($urandom_range(0, 1) ? 512 : 16);
        q.sx = rand_coord(span); q.sy = rand_coord(span); q.sz = rand_coord(span);
        q.ex = rand_coord(span); q.ey = rand_coord(span); q.ez = rand_coord(span);
        q.qx = rand_coord(span); q.qy = rand_coord(span); q.qz = rand_coord(span);
        if (pick >= 7) begin
            // point near the segment line, projection often inside or on an end
            t = $urandom_range(0, 8);
            q.qx = q.sx + (q.ex - q.sx) * t / 8 + rand_coord(8);
            q.qy = q.sy + (q.ey - q.sy) * t / 8 + rand_coord(8);
            q.qz = q.sz + (q.ez - q.sz) * t / 8 + rand_coord(8);
            if (pick == 9) begin
                q.ex = q.sx;
                q.ey = q.sy;
                q.ez = q.sz;
            end
        end
        return q;
    endfunction

    function automatic t_seg_query mk(input int sx, sy, sz, ex, ey, ez, qx, qy, qz);
        t_seg_query q;
        q = '{t_coord'(sx), t_coord'(sy), t_coord'(sz), t_coord'(ex), t_coord'(ey),
              t_coord'(ez), t_coord'(qx), t_coord'(qy), t_coord'(qz)};
        return q;
    endfunction

    task automatic add_query(input t_seg_query q);
        query_queue = {query_queue, q};
    endtask

    // acceptance and prediction
    always @(posedge i_clk) begin
        t_dist_result pred;
        beat_taken <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) begin
            pred = predict_distance('{i_start_x, i_start_y, i_start_z,
                i_end_x, i_end_y, i_end_z, i_query_x, i_query_y, i_query_z});
            expected_dist = {expected_dist, pred};
        end
    end

    // driver
    always @(negedge i_clk) begin
        t_seg_query q;
        if (i_rst_n && (!start || beat_taken)) begin
            if (gap_left > 0 || query_queue.size() == 0) begin
                start <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                q = query_queue.pop_front();
                {i_start_x, i_start_y, i_start_z} <= {q.sx, q.sy, q.sz};
                {i_end_x, i_end_y, i_end_z}       <= {q.ex, q.ey, q.ez};
                {i_query_x, i_query_y, i_query_z} <= {q.qx, q.qy, q.qz};
                start <= 1'b1;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                    gap_left   <= 0;
                end else if ($urandom_range(0, 99) < 3) begin
                    burst_left <= $urandom_range(10, 60);
                    gap_left   <= 0;
                end else begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left <= 0;
                        9:          gap_left <= $urandom_range(8, 40);
                        default:    gap_left <= $urandom_range(1, 3);
                    endcase
                end
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_dist_result exp_r;
        if (i_rst_n && o_valid) begin
            if (expected_dist.size() == 0) begin
                $error("result beat with nothing expected");
                error_count++;
            end else begin
                exp_r = expected_dist.pop_front();
                if (o_seg_distance !== exp_r.distance) begin
                    $error("seg_distance expected %0d actual %0d", exp_r.distance,
                           o_seg_distance);
                    error_count++;
                end
                if (o_region !== exp_r.region) begin
                    $error("region expected %0d actual %0d", exp_r.region, o_region);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("point_segment_distance test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        {i_start_x, i_start_y, i_start_z} = '0;
        {i_end_x, i_end_y, i_end_z} = '0;
        {i_query_x, i_query_y, i_query_z} = '0;
        beat_taken = 1'b0;
        gap_left = 0;
        burst_left = 0;
        error_count = 0;
        cycle_count = 0;

        // directed: degenerate segment, endpoint regions, interior and projections on the ends
        add_query(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_query(mk(16, 32, -48, 16, 32, -48, 100, -7, 3));
        add_query(mk(-32768, -32768, -32768, -32768, -32768, -32768,
                     32767, 32767, 32767));
        add_query(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                     32767, -32768, 0));
        add_query(mk(32767, 32767, 32767, -32768, -32768, -32768,
                     -32768, -32768, -32768));
        add_query(mk(-32768, -32768, -32768, 32767, -32768, -32768,
                     32767, 32767, 32767));
        add_query(mk(0, 0, 0, 160, 0, 0, -16, 16, 0));
        add_query(mk(0, 0, 0, 160, 0, 0, 200, 0, 30));
        add_query(mk(0, 0, 0, 160, 0, 0, 80, 48, 64));
        add_query(mk(0, 0, 0, 160, 0, 0, 0, 48, 64));
        add_query(mk(0, 0, 0, 160, 0, 0, 160, -48, 64));
        add_query(mk(5, 7, 9, 21, -3, 40, 13, 2, 24));
        add_query(mk(1, 1, 1, 2, 3, 5, 100, -200, 7));
        add_query(mk(32767, 0, -32768, 32767, 0, -32768, -32768, 0, 32767));
        add_query(mk(-1, -1, -1, 1, 1, 1, 0, 0, 0));
        add_query(mk(-32768, 32767, 0, 32767, -32768, 0, 0, 0, 32767));
        for (int i = 0; i < 1034; i++) add_query(rand_query());

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (query_queue.size() > 0 || start) @(posedge i_clk);
        while (expected_dist.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("point_segment_distance test passed");
        end else begin
            $display("point_segment_distance test failed");
        end
        $finish;
    end

endmodule
